[hdl/mnpr_pkg.sv]
// shared types, codes and constants of the midi note pair recorder
package mnpr_pkg;

    localparam int FRAME_W        = 40;
    localparam int TAKE_NOTES_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int S_TDATA_W      = 64;
    localparam int S_TUSER_W      = 3;
    localparam int M_TDATA_W      = 168;
    localparam int CFG_IDX_W      = 1;
    localparam int CNT32_W        = 32;

    // func codes on the slave side
    localparam logic [1:0] FUNC_EVENT  = 2'd0;
    localparam logic [1:0] FUNC_ARM    = 2'd1;
    localparam logic [1:0] FUNC_DISARM = 2'd2;
    localparam logic [1:0] FUNC_STOP   = 2'd3;

    // classified request kinds
    localparam logic [2:0] KIND_ON     = 3'd0;
    localparam logic [2:0] KIND_OFF    = 3'd1;
    localparam logic [2:0] KIND_ARM    = 3'd2;
    localparam logic [2:0] KIND_DISARM = 3'd3;
    localparam logic [2:0] KIND_STOP   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT = 1'b1;

    typedef struct packed {
        logic [2:0]         kind;
        logic               bad;
        logic [FRAME_W-1:0] frame;
        logic [7:0]         pitch;
        logic [7:0]         channel;
        logic [6:0]         velocity;
    } item_t;

    typedef struct packed {
        logic [FRAME_W-1:0] start;
        logic [6:0]         pitch;
        logic [3:0]         channel;
        logic [6:0]         velocity;
    } held_t;

    typedef struct packed {
        logic [FRAME_W-1:0] start;
        logic [FRAME_W-1:0] length;
        logic [6:0]         pitch;
        logic [3:0]         channel;
        logic [6:0]         velocity;
    } note_t;

endpackage

[hdl/mnpr_front.sv]
// front end: decodes slave requests into classified items
module mnpr_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mnpr_pkg::S_TDATA_W-1:0] s_tdata,   // frame, pitch, channel, velocity
    input  logic [mnpr_pkg::S_TUSER_W-1:0] s_tuser,   // func[1:0], note_off
    output mnpr_pkg::item_t                q_item,
    output logic                           q_valid,
    input  logic                           q_ready
);
    import mnpr_pkg::*;

    item_t dec;
    item_t item_reg, item_next;
    logic  vld_reg, vld_next;
    logic  accept;

    // field decode and malformed check
    always_comb
    begin
        dec.frame    = s_tdata[FRAME_W-1:0];
        dec.pitch    = s_tdata[47:40];
        dec.channel  = s_tdata[55:48];
        dec.velocity = s_tdata[62:56];
        dec.bad      = (s_tdata[63:56] == 8'd0) || s_tdata[63] || s_tdata[47]
                       || (s_tdata[55:52] != 4'd0);
        unique case (s_tuser[1:0])
            FUNC_EVENT:  dec.kind = s_tuser[2] ? KIND_OFF : KIND_ON;
            FUNC_ARM:    dec.kind = KIND_ARM;
            FUNC_DISARM: dec.kind = KIND_DISARM;
            FUNC_STOP:   dec.kind = KIND_STOP;
            default:     dec.kind = KIND_STOP;
        endcase
    end

    // one register stage toward the queue
    assign s_tready = !vld_reg || q_ready;
    assign accept   = s_tvalid && s_tready;
    assign q_item   = item_reg;
    assign q_valid  = vld_reg;

    always_comb
    begin
        item_next = item_reg;
        vld_next  = vld_reg;
        if (q_ready)
        begin
            vld_next = 1'b0;
        end
        if (accept)
        begin
            item_next = dec;
            vld_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

[hdl/mnpr_queue.sv]
// short queue between front end and back end
module mnpr_queue #(
    parameter int DEPTH = mnpr_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mnpr_pkg::item_t in_item,
    input  logic            in_valid,
    output logic            in_ready,
    output mnpr_pkg::item_t out_item,
    output logic            out_valid,
    input  logic            out_ready
);
    import mnpr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            q_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg < CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = q_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[hdl/mnpr_back.sv]
// back end: held note cells, committed note memory, stop drain and output register
module mnpr_back #(
    parameter int TAKE_NOTES = mnpr_pkg::TAKE_NOTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mnpr_pkg::item_t                q_item,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mnpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mnpr_pkg::FRAME_W-1:0]   cfg_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mnpr_pkg::M_TDATA_W-1:0] m_tdata,   // start, length, pitch, channel,
                                                      // velocity, dropped, unmatched
    output logic                           m_tuser,   // note_valid
    output logic                           m_tlast
);
    import mnpr_pkg::*;

    localparam int IDX_W = (TAKE_NOTES > 1) ? $clog2(TAKE_NOTES) : 1;
    localparam int CNT_W = $clog2(TAKE_NOTES + 1);

    localparam logic [3:0] ST_IDLE         = 4'd0;
    localparam logic [3:0] ST_EV_CLAMP     = 4'd1;
    localparam logic [3:0] ST_EV_FIND      = 4'd2;
    localparam logic [3:0] ST_EV_ACT       = 4'd3;
    localparam logic [3:0] ST_COMMIT_DIFF  = 4'd4;
    localparam logic [3:0] ST_COMMIT_WRITE = 4'd5;
    localparam logic [3:0] ST_STOP_CLAMP   = 4'd6;
    localparam logic [3:0] ST_STOP_CAP     = 4'd7;
    localparam logic [3:0] ST_STOP_LOAD    = 4'd8;
    localparam logic [3:0] ST_DRAIN_START  = 4'd9;
    localparam logic [3:0] ST_DRAIN_ADDR   = 4'd10;
    localparam logic [3:0] ST_DRAIN_LOAD   = 4'd11;
    localparam logic [3:0] ST_MARK         = 4'd12;

    logic [3:0]         state_reg, state_next;
    item_t              cur_reg, cur_next;
    logic               armed_reg, armed_next;
    logic [CNT_W-1:0]   open_cnt_reg, open_cnt_next;
    logic [CNT_W-1:0]   done_cnt_reg, done_cnt_next;
    logic [FRAME_W-1:0] last_frame_reg, last_frame_next;
    logic [CNT32_W-1:0] dropped_reg, dropped_next;
    logic [CNT32_W-1:0] unmatched_reg, unmatched_next;
    logic [FRAME_W-1:0] cap_reg, cap_next;
    logic [FRAME_W-1:0] limit_reg, limit_next;
    logic [FRAME_W-1:0] top_reg, top_next;

    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [FRAME_W-1:0] end_reg, end_next;
    logic [FRAME_W:0]   diff_reg, diff_next;
    held_t              hold_reg, hold_next;
    logic [IDX_W-1:0]   rm_idx_reg, rm_idx_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic               found_reg, found_next;
    logic               drop_reg, drop_next;
    logic               stop_mode_reg, stop_mode_next;
    logic [IDX_W-1:0]   drain_idx_reg, drain_idx_next;
    logic [TAKE_NOTES-1:0] match_reg, match_next;

    held_t              cell_reg [TAKE_NOTES];
    held_t              cell_next [TAKE_NOTES];
    logic               shift_en, app_en;
    held_t              app_val;

    note_t              done_mem [TAKE_NOTES];
    note_t              rd_data_reg;
    logic               mem_we;
    note_t              mem_wd;
    logic [FRAME_W-1:0] len_val;

    logic               out_valid_reg, out_valid_next;
    note_t              out_note_reg, out_note_next;
    logic               out_flag_reg, out_flag_next;
    logic               out_last_reg, out_last_next;
    logic [CNT32_W-1:0] out_drop_reg, out_drop_next;
    logic [CNT32_W-1:0] out_unm_reg, out_unm_next;
    logic               can_load;
    logic               is_last;

    assign q_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign can_load  = !out_valid_reg || m_tready;
    assign is_last   = CNT_W'(drain_idx_reg) == (done_cnt_reg - 1'b1);

    // capped note length from the registered difference
    always_comb
    begin
        if (diff_reg[FRAME_W] || (diff_reg == '0))
        begin
            len_val = FRAME_W'(1);
        end
        else if (diff_reg[FRAME_W-1:0] < cap_reg)
        begin
            len_val = diff_reg[FRAME_W-1:0];
        end
        else
        begin
            len_val = cap_reg;
        end
    end

    // main sequencer
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        armed_next      = armed_reg;
        open_cnt_next   = open_cnt_reg;
        done_cnt_next   = done_cnt_reg;
        last_frame_next = last_frame_reg;
        dropped_next    = dropped_reg;
        unmatched_next  = unmatched_reg;
        frame_next      = frame_reg;
        end_next        = end_reg;
        diff_next       = diff_reg;
        hold_next       = hold_reg;
        rm_idx_next     = rm_idx_reg;
        k_next          = k_reg;
        found_next      = found_reg;
        drop_next       = drop_reg;
        stop_mode_next  = stop_mode_reg;
        drain_idx_next  = drain_idx_reg;
        match_next      = match_reg;
        shift_en        = 1'b0;
        app_en          = 1'b0;
        app_val         = '0;
        mem_we          = 1'b0;
        mem_wd          = '0;
        out_valid_next  = out_valid_reg && !m_tready;
        out_note_next   = out_note_reg;
        out_flag_next   = out_flag_reg;
        out_last_next   = out_last_reg;
        out_drop_next   = out_drop_reg;
        out_unm_next    = out_unm_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cur_next = q_item;
                    case (q_item.kind)
                        KIND_ON, KIND_OFF:
                        begin
                            state_next = armed_reg ? ST_EV_CLAMP : ST_IDLE;
                        end
                        KIND_ARM:
                        begin
                            open_cnt_next   = '0;
                            done_cnt_next   = '0;
                            last_frame_next = '0;
                            dropped_next    = '0;
                            unmatched_next  = '0;
                            armed_next      = 1'b1;
                        end
                        KIND_DISARM:
                        begin
                            open_cnt_next   = '0;
                            done_cnt_next   = '0;
                            last_frame_next = '0;
                            armed_next      = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_STOP_CLAMP;
                        end
                    endcase
                end
            end
            ST_EV_CLAMP:
            begin
                // clamp a late frame and compare every held cell
                frame_next = (cur_reg.frame < last_frame_reg) ? last_frame_reg : cur_reg.frame;
                for (int i = 0; i < TAKE_NOTES; i++)
                begin
                    match_next[i] = (CNT_W'(i) < open_cnt_reg)
                                    && ({1'b0, cell_reg[i].pitch} == cur_reg.pitch)
                                    && ({4'd0, cell_reg[i].channel} == cur_reg.channel);
                end
                state_next = ST_EV_FIND;
            end
            ST_EV_FIND:
            begin
                // newest matching cell, and note-on refusal
                found_next = 1'b0;
                k_next     = '0;
                for (int i = 0; i < TAKE_NOTES; i++)
                begin
                    if (match_reg[i])
                    begin
                        found_next = 1'b1;
                        k_next     = IDX_W'(i);
                    end
                end
                drop_next = cur_reg.bad || (frame_reg >= limit_reg)
                            || (({1'b0, open_cnt_reg} + {1'b0, done_cnt_reg})
                                >= (CNT_W + 1)'(TAKE_NOTES));
                state_next = ST_EV_ACT;
            end
            ST_EV_ACT:
            begin
                state_next = ST_IDLE;
                if (cur_reg.kind == KIND_OFF)
                begin
                    if (!found_reg)
                    begin
                        if (unmatched_reg != '1)
                        begin
                            unmatched_next = unmatched_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        hold_next       = cell_reg[k_reg];
                        rm_idx_next     = k_reg;
                        last_frame_next = frame_reg;
                        end_next        = frame_reg;
                        stop_mode_next  = 1'b0;
                        state_next      = ST_COMMIT_DIFF;
                    end
                end
                else if (drop_reg)
                begin
                    if (dropped_reg != '1)
                    begin
                        dropped_next = dropped_reg + 1'b1;
                    end
                end
                else
                begin
                    app_en           = 1'b1;
                    app_val.start    = frame_reg;
                    app_val.pitch    = cur_reg.pitch[6:0];
                    app_val.channel  = cur_reg.channel[3:0];
                    app_val.velocity = cur_reg.velocity;
                    open_cnt_next    = open_cnt_reg + 1'b1;
                    last_frame_next  = frame_reg;
                end
            end
            ST_COMMIT_DIFF:
            begin
                diff_next  = {1'b0, end_reg} - {1'b0, hold_reg.start};
                state_next = ST_COMMIT_WRITE;
            end
            ST_COMMIT_WRITE:
            begin
                // commit the held note and close the gap in the cells
                if (done_cnt_reg < CNT_W'(TAKE_NOTES))
                begin
                    mem_we          = 1'b1;
                    mem_wd.start    = hold_reg.start;
                    mem_wd.length   = len_val;
                    mem_wd.pitch    = hold_reg.pitch;
                    mem_wd.channel  = hold_reg.channel;
                    mem_wd.velocity = hold_reg.velocity;
                    done_cnt_next   = done_cnt_reg + 1'b1;
                end
                shift_en      = 1'b1;
                open_cnt_next = open_cnt_reg - 1'b1;
                if (!stop_mode_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (open_cnt_reg > CNT_W'(1))
                begin
                    state_next = ST_STOP_LOAD;
                end
                else
                begin
                    state_next = ST_DRAIN_START;
                end
            end
            ST_STOP_CLAMP:
            begin
                end_next   = (cur_reg.frame < last_frame_reg) ? last_frame_reg : cur_reg.frame;
                state_next = ST_STOP_CAP;
            end
            ST_STOP_CAP:
            begin
                end_next       = (end_reg > top_reg) ? top_reg : end_reg;
                stop_mode_next = 1'b1;
                state_next     = (open_cnt_reg != '0) ? ST_STOP_LOAD : ST_DRAIN_START;
            end
            ST_STOP_LOAD:
            begin
                hold_next   = cell_reg[0];
                rm_idx_next = '0;
                state_next  = ST_COMMIT_DIFF;
            end
            ST_DRAIN_START:
            begin
                armed_next     = 1'b0;
                drain_idx_next = '0;
                state_next     = (done_cnt_reg == '0) ? ST_MARK : ST_DRAIN_ADDR;
            end
            ST_DRAIN_ADDR:
            begin
                state_next = ST_DRAIN_LOAD;
            end
            ST_DRAIN_LOAD:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_note_next  = rd_data_reg;
                    out_flag_next  = 1'b1;
                    out_last_next  = is_last;
                    out_drop_next  = dropped_reg;
                    out_unm_next   = unmatched_reg;
                    if (is_last)
                    begin
                        done_cnt_next = '0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        drain_idx_next = drain_idx_reg + 1'b1;
                        state_next     = ST_DRAIN_ADDR;
                    end
                end
            end
            ST_MARK:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_note_next  = '0;
                    out_flag_next  = 1'b0;
                    out_last_next  = 1'b1;
                    out_drop_next  = dropped_reg;
                    out_unm_next   = unmatched_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration writes
    always_comb
    begin
        cap_next   = cap_reg;
        limit_next = limit_reg;
        top_next   = top_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MAX_LEN:
                begin
                    cap_next = (cfg_data == '0) ? FRAME_W'(1) : cfg_data;
                end
                REG_FRAME_LIMIT:
                begin
                    limit_next = cfg_data;
                    top_next   = (cfg_data == '0) ? '0 : cfg_data - 1'b1;
                end
                default:
                begin
                    cap_next = cap_reg;
                end
            endcase
        end
    end

    // held note cells: append at the fill point or shift down over a removed cell
    for (genvar g = 0; g < TAKE_NOTES; g++)
    begin : g_cell
        always_comb
        begin
            cell_next[g] = cell_reg[g];
            if (app_en && (open_cnt_reg[IDX_W-1:0] == IDX_W'(g)))
            begin
                cell_next[g] = app_val;
            end
            if (g < TAKE_NOTES - 1)
            begin
                if (shift_en && (IDX_W'(g) >= rm_idx_reg))
                begin
                    cell_next[g] = cell_reg[(g < TAKE_NOTES - 1) ? g + 1 : g];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            cell_reg[g] <= cell_next[g];
        end
    end

    // committed note memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            done_mem[done_cnt_reg[IDX_W-1:0]] <= mem_wd;
        end
        rd_data_reg <= done_mem[drain_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            armed_reg      <= 1'b0;
            open_cnt_reg   <= '0;
            done_cnt_reg   <= '0;
            last_frame_reg <= '0;
            dropped_reg    <= '0;
            unmatched_reg  <= '0;
            cap_reg        <= '1;
            limit_reg      <= '1;
            top_reg        <= {{(FRAME_W - 1){1'b1}}, 1'b0};
            stop_mode_reg  <= 1'b0;
            drain_idx_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            armed_reg      <= armed_next;
            open_cnt_reg   <= open_cnt_next;
            done_cnt_reg   <= done_cnt_next;
            last_frame_reg <= last_frame_next;
            dropped_reg    <= dropped_next;
            unmatched_reg  <= unmatched_next;
            cap_reg        <= cap_next;
            limit_reg      <= limit_next;
            top_reg        <= top_next;
            stop_mode_reg  <= stop_mode_next;
            drain_idx_reg  <= drain_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        frame_reg    <= frame_next;
        end_reg      <= end_next;
        diff_reg     <= diff_next;
        hold_reg     <= hold_next;
        rm_idx_reg   <= rm_idx_next;
        k_reg        <= k_next;
        found_reg    <= found_next;
        drop_reg     <= drop_next;
        match_reg    <= match_next;
        out_note_reg <= out_note_next;
        out_flag_reg <= out_flag_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
        out_unm_reg  <= out_unm_next;
    end

    // output port packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_flag_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_unm_reg, out_drop_reg, out_note_reg.velocity,
                       out_note_reg.channel, out_note_reg.pitch, out_note_reg.length,
                       out_note_reg.start};

    // take never holds more notes than it has room for
    a_take_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((CNT_W + 1)'(open_cnt_reg) + (CNT_W + 1)'(done_cnt_reg))
            <= (CNT_W + 1)'(TAKE_NOTES))
        else $error("take holds more notes than its capacity");

    // an idle disarmed recorder holds no notes
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !armed_reg) |-> (open_cnt_reg == '0 && done_cnt_reg == '0))
        else $error("notes left over while disarmed");

    // a popped stop request starts the stop sequence
    a_stop_start: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready && q_item.kind == KIND_STOP) |=> (state_reg == ST_STOP_CLAMP))
        else $error("stop request not started");

endmodule

[hdl/midi_note_pair_recorder.sv]
// midi note pair recorder top level
//
// Slave stream: one request per item; tuser carries func and note_off, tdata the
// frame, pitch, channel and velocity. Configuration channel writes max_note_length
// (index 0) and frame_limit (index 1); it is always ready. It must be written only while
// idle; the block itself does not enforce this. Master stream: results appear only for a
// stop request: one per recorded note, committed notes first, then still-held ones, with
// tlast on the final one; an empty take gives one result with tuser low.
// An event request passes through the clamp, find and act states of the back end; a
// note-off that closes a note goes on through the diff and write states (the length
// subtract is registered, then capped). A stop clamps and caps its frame, commits each
// held note through the load, diff and write states, then sets up the drain and reads
// each result from the committed note memory, whose read port is registered. A
// two-entry queue and an input stage let the front accept while the back end works.
// Reset clears the take, counters and armed state, and sets both registers to all
// ones. A stalled master holds the output register; the drain waits on it and the
// queue fills and then lowers s_tready.
module midi_note_pair_recorder #(
    parameter int TAKE_NOTES  = mnpr_pkg::TAKE_NOTES_DEF,
    parameter int QUEUE_DEPTH = mnpr_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mnpr_pkg::S_TDATA_W-1:0] s_tdata,   // frame, pitch, channel, velocity
    input  logic [mnpr_pkg::S_TUSER_W-1:0] s_tuser,   // func[1:0], note_off
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mnpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mnpr_pkg::FRAME_W-1:0]   cfg_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mnpr_pkg::M_TDATA_W-1:0] m_tdata,   // start, length, pitch, channel,
                                                      // velocity, dropped, unmatched
    output logic                           m_tuser,   // note_valid
    output logic                           m_tlast
);
    import mnpr_pkg::*;

    item_t f_item, b_item;
    logic  f_valid, f_ready, b_valid, b_ready;

    // request decode
    mnpr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_item   (f_item),
        .q_valid  (f_valid),
        .q_ready  (f_ready)
    );

    // decoupling queue
    mnpr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (f_item),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .out_item  (b_item),
        .out_valid (b_valid),
        .out_ready (b_ready)
    );

    // note pairing and take drain
    mnpr_back #(
        .TAKE_NOTES (TAKE_NOTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (b_item),
        .q_valid   (b_valid),
        .q_ready   (b_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[dv/tb.sv]
// testbench for the midi note pair recorder: random take sequences checked against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mnpr_pkg::*;

    localparam int TAKE_MAX = 32;
    localparam logic [39:0] ALL40 = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  func;
        logic        note_off;
        logic [39:0] frame;
        logic [7:0]  pitch;
        logic [7:0]  channel;
        logic [7:0]  velocity;
    } midi_req_t;

    typedef struct packed {
        logic        valid;
        logic [39:0] start;
        logic [39:0] length;
        logic [6:0]  pitch;
        logic [3:0]  channel;
        logic [6:0]  velocity;
        logic        last;
        logic [31:0] dropped;
        logic [31:0] unmatched;
    } take_note_t;

    typedef struct packed {
        logic [39:0] start;
        logic [7:0]  pitch;
        logic [7:0]  channel;
        logic [7:0]  velocity;
    } open_note_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FRAME_W-1:0] cfg_data;
    logic m_tvalid;
    logic m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    midi_note_pair_recorder i_dut (.*);

    // predictor state
    logic [39:0] max_len_reg;
    logic [39:0] limit_reg;
    open_note_t  held_q[$];
    take_note_t  closed_q[$];
    logic [39:0] last_frame;
    logic        armed;
    logic [31:0] dropped_cnt;
    logic [31:0] unmatched_cnt;

    midi_req_t   pending_q[$];
    take_note_t  expected_notes[$];
    int          fail_count;
    int          note_count;
    int          req_count;
    int          stop_count;
    longint      cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h (note %0d)", what, got, want, note_count);
        fail_count++;
    endtask

    // append one request to the stimulus queue
    task automatic queue_req(input midi_req_t r);
        pending_q = {pending_q, r};
    endtask

    function automatic logic [39:0] note_len(input logic [39:0] s, input logic [39:0] e);
        logic [39:0] cap;
        logic [39:0] d;
        cap = (max_len_reg == 0) ? 40'd1 : max_len_reg;
        if (e <= s)
            return 40'd1;
        d = e - s;
        return (d < cap) ? d : cap;
    endfunction

    function automatic void close_note(input open_note_t h, input logic [39:0] e);
        take_note_t n;
        if (closed_q.size() >= TAKE_MAX)
            return;
        n = '0;
        n.valid    = 1'b1;
        n.start    = h.start;
        n.length   = note_len(h.start, e);
        n.pitch    = h.pitch[6:0];
        n.channel  = h.channel[3:0];
        n.velocity = h.velocity[6:0];
        closed_q = {closed_q, n};
    endfunction

    // expected results of one accepted request
    function automatic void predict_take(input midi_req_t r);
        logic [39:0] f;
        logic [39:0] top;
        take_note_t  n;
        bit          hit;
        case (r.func)
            FUNC_EVENT:
            begin
                if (!armed)
                    return;
                f = (r.frame < last_frame) ? last_frame : r.frame;
                if (r.note_off)
                begin
                    hit = 0;
                    for (int k = held_q.size() - 1; k >= 0 && !hit; k--)
                        if (held_q[k].pitch == r.pitch && held_q[k].channel == r.channel)
                        begin
                            open_note_t h;
                            h = held_q[k];
                            held_q.delete(k);
                            last_frame = f;
                            close_note(h, f);
                            hit = 1;
                        end
                    if (!hit && unmatched_cnt != '1)
                        unmatched_cnt++;
                end
                else if (r.velocity < 1 || r.velocity > 127 || r.pitch > 127 ||
                         r.channel > 15 || f >= limit_reg ||
                         held_q.size() + closed_q.size() >= TAKE_MAX)
                begin
                    if (dropped_cnt != '1)
                        dropped_cnt++;
                end
                else
                begin
                    open_note_t h;
                    last_frame = f;
                    h.start = f;
                    h.pitch = r.pitch;
                    h.channel = r.channel;
                    h.velocity = r.velocity;
                    held_q = {held_q, h};
                end
            end
            FUNC_ARM:
            begin
                held_q.delete();
                closed_q.delete();
                last_frame = 0;
                dropped_cnt = 0;
                unmatched_cnt = 0;
                armed = 1;
            end
            FUNC_DISARM:
            begin
                held_q.delete();
                closed_q.delete();
                last_frame = 0;
                armed = 0;
            end
            default:
            begin
                f = r.frame;
                top = (limit_reg == 0) ? 40'd0 : limit_reg - 40'd1;
                if (f < last_frame)
                    f = last_frame;
                if (f > top)
                    f = top;
                foreach (held_q[i])
                    close_note(held_q[i], f);
                held_q.delete();
                armed = 0;
                if (closed_q.size() == 0)
                begin
                    n = '0;
                    n.last = 1'b1;
                    n.dropped = dropped_cnt;
                    n.unmatched = unmatched_cnt;
                    expected_notes = {expected_notes, n};
                end
                foreach (closed_q[i])
                begin
                    n = closed_q[i];
                    n.last = (i == closed_q.size() - 1);
                    n.dropped = dropped_cnt;
                    n.unmatched = unmatched_cnt;
                    expected_notes = {expected_notes, n};
                end
                closed_q.delete();
            end
        endcase
    endfunction

    // driver: bursts and gaps
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            midi_req_t r;
            bit        take;
            if (s_tvalid && s_tready)
            begin
                predict_take(pending_q.pop_front());
                req_count++;
            end
            take = 0;
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (pending_q.size() > 0)
                begin
                    take = 1;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                if (take)
                begin
                    r = pending_q[0];
                    s_tdata <= {r.velocity, r.channel, r.pitch, r.frame};
                    s_tuser <= {r.note_off, r.func};
                end
                s_tvalid <= take;
            end
        end
    end

    // receiver stall pattern and result check
    int stall_mode;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            take_note_t got;
            take_note_t want;
            if (m_tvalid && m_tready)
            begin
                got.valid = m_tuser;
                {got.unmatched, got.dropped, got.velocity, got.channel, got.pitch,
                 got.length, got.start} = m_tdata[161:0];
                got.last = m_tlast;
                if (expected_notes.size() == 0)
                    report_mismatch("unexpected result start", 64'(got.start), '0);
                else
                begin
                    want = expected_notes.pop_front();
                    if (got.valid !== want.valid)
                        report_mismatch("note_valid", 64'(got.valid), 64'(want.valid));
                    if (got.start !== want.start)
                        report_mismatch("start", 64'(got.start), 64'(want.start));
                    if (got.length !== want.length)
                        report_mismatch("length", 64'(got.length), 64'(want.length));
                    if (got.pitch !== want.pitch)
                        report_mismatch("pitch", 64'(got.pitch), 64'(want.pitch));
                    if (got.channel !== want.channel)
                        report_mismatch("channel", 64'(got.channel), 64'(want.channel));
                    if (got.velocity !== want.velocity)
                        report_mismatch("velocity", 64'(got.velocity), 64'(want.velocity));
                    if (got.last !== want.last)
                        report_mismatch("last", 64'(got.last), 64'(want.last));
                    if (got.dropped !== want.dropped)
                        report_mismatch("dropped", 64'(got.dropped), 64'(want.dropped));
                    if (got.unmatched !== want.unmatched)
                        report_mismatch("unmatched", 64'(got.unmatched),
                                        64'(want.unmatched));
                end
                note_count++;
            end
            if ((cycle_count & 511) == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ((cycle_count % 7) < 3);
            endcase
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic midi_req_t mk(input logic [1:0] fn, input int off,
                                     input logic [39:0] fr, input int p,
                                     input int c, input int v);
        midi_req_t r;
        r.func = fn;
        r.note_off = 1'(off);
        r.frame = fr;
        r.pitch = 8'(p);
        r.channel = 8'(c);
        r.velocity = 8'(v);
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [39:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_MAX_LEN)
            max_len_reg = val;
        else
            limit_reg = val;
    endtask

    // wait for the block to finish all requests
    task automatic wait_idle();
        while (pending_q.size() > 0 || s_tvalid || expected_notes.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // one random take, mostly well formed
    task automatic queue_take(input int n_events, input logic [39:0] base);
        logic [39:0] fr;
        fr = base;
        queue_req(mk(FUNC_ARM, 0, 40'($urandom), 0, 0, 0));
        for (int i = 0; i < n_events; i++)
        begin
            midi_req_t r;
            int sel;
            sel = $urandom_range(0, 19);
            fr = fr + 40'($urandom_range(0, 50));
            r = mk(FUNC_EVENT, $urandom_range(0, 1), fr, $urandom_range(60, 63),
                   $urandom_range(0, 1), $urandom_range(1, 127));
            if (sel == 0)
                r.frame = 40'({$urandom, $urandom});
            else if (sel == 1)
                r.frame = fr - 40'($urandom_range(0, 100));
            else if (sel == 2)
            begin
                r.pitch = 8'($urandom);
                r.channel = 8'($urandom);
                r.velocity = 8'($urandom);
            end
            else if (sel == 3)
                r.func = FUNC_DISARM;
            else if (sel == 4 && $urandom_range(0, 3) == 0)
                r.func = FUNC_ARM;
            queue_req(r);
        end
        queue_req(mk(FUNC_STOP, 0, fr + 40'($urandom_range(0, 300)), 0, 0, 0));
        stop_count++;
    endtask

    initial
    begin
        logic [39:0] lims[4];
        logic [39:0] lens[4];
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        max_len_reg = ALL40;
        limit_reg = ALL40;
        last_frame = 0;
        armed = 0;
        dropped_cnt = 0;
        unmatched_cnt = 0;
        fail_count = 0;
        note_count = 0;
        req_count = 0;
        stop_count = 0;
        cycle_count = 0;
        stall_mode = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, malformed events, full take, stop while not armed
        queue_req(mk(FUNC_STOP, 0, ALL40, 0, 0, 0));
        queue_req(mk(FUNC_EVENT, 0, 40'd10, 60, 0, 100));
        queue_req(mk(FUNC_ARM, 0, 40'd0, 0, 0, 0));
        queue_req(mk(FUNC_EVENT, 0, 40'd0, 127, 15, 127));
        queue_req(mk(FUNC_EVENT, 0, 40'd5, 0, 0, 1));
        queue_req(mk(FUNC_EVENT, 0, 40'd6, 128, 0, 1));
        queue_req(mk(FUNC_EVENT, 0, 40'd6, 1, 16, 1));
        queue_req(mk(FUNC_EVENT, 0, 40'd6, 1, 1, 0));
        queue_req(mk(FUNC_EVENT, 0, 40'd6, 255, 255, 255));
        queue_req(mk(FUNC_EVENT, 0, 40'd7, 0, 0, 1));
        queue_req(mk(FUNC_EVENT, 1, 40'd3, 0, 0, 0));
        queue_req(mk(FUNC_EVENT, 1, 40'd9, 5, 5, 0));
        queue_req(mk(FUNC_EVENT, 1, ALL40, 127, 15, 0));
        queue_req(mk(FUNC_EVENT, 0, ALL40, 1, 2, 3));
        queue_req(mk(FUNC_STOP, 0, 40'd0, 0, 0, 0));
        queue_req(mk(FUNC_ARM, 0, 40'd0, 0, 0, 0));
        queue_req(mk(FUNC_DISARM, 0, 40'd0, 0, 0, 0));
        queue_req(mk(FUNC_STOP, 0, 40'd20, 0, 0, 0));
        queue_req(mk(FUNC_ARM, 0, 40'd0, 0, 0, 0));
        for (int i = 0; i < 34; i++)
            queue_req(mk(FUNC_EVENT, int'(i % 3 == 0), 40'(i * 3), i % 4, 0, 64));
        queue_req(mk(FUNC_STOP, 0, 40'd1000, 0, 0, 0));
        stop_count += 4;
        wait_idle();

        // random takes over several register settings, extremes included
        lims = '{40'd0, 40'd1, 40'd400, ALL40};
        lens = '{40'd0, 40'd1, 40'd37, ALL40};
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_MAX_LEN, (ph < 4) ? lens[ph] : lens[$urandom_range(0, 3)]);
            write_reg(REG_FRAME_LIMIT, (ph < 4) ? lims[3 - ph] : lims[$urandom_range(1, 3)]);
            for (int t = 0; t < 3; t++)
                queue_take($urandom_range(4, 22),
                           ($urandom_range(0, 4) == 0) ? (ALL40 - 40'd500) : 40'd0);
            wait_idle();
        end

        $display("covered %0d requests in %0d stops, %0d results checked",
                 req_count, stop_count, note_count);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

[midi_note_pair_recorder.f]
hdl/mnpr_pkg.sv
hdl/mnpr_front.sv
hdl/mnpr_queue.sv
hdl/mnpr_back.sv
hdl/midi_note_pair_recorder.sv
dv/tb.sv
